### hdl/phvc_pkg.sv
// Package: shared types and constants for the position-hold velocity controller.
`timescale 1ns / 1ps
package phvc_pkg;
    localparam int ACCEL_LIMIT_XY_DEF    = 500;
    localparam int ACCEL_LIMIT_Z_DEF     = 300;
    localparam int SIGNAL_TIMEOUT_MS_DEF = 500;
    localparam int RANGE_XY_MM_DEF       = 15000;
    localparam int RANGE_Z_MM_DEF        = 5000;
    localparam int MIN_Z_MM_DEF          = 300;

    localparam logic [2:0] MODE_NO_SIGNAL = 3'd0;
    localparam logic [2:0] MODE_LOST      = 3'd1;
    localparam logic [2:0] MODE_NOT_READY = 3'd2;
    localparam logic [2:0] MODE_REACHED   = 3'd3;
    localparam logic [2:0] MODE_NAV       = 3'd4;

    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_REACHED = 2'd1;
    localparam logic [1:0] EVT_LEFT    = 2'd2;

    localparam logic [2:0] REG_TX  = 3'd0;
    localparam logic [2:0] REG_TY  = 3'd1;
    localparam logic [2:0] REG_TZ  = 3'd2;
    localparam logic [2:0] REG_GXY = 3'd3;
    localparam logic [2:0] REG_GZ  = 3'd4;
    localparam logic [2:0] REG_LXY = 3'd5;
    localparam logic [2:0] REG_LZ  = 3'd6;
    localparam logic [2:0] REG_DB  = 3'd7;

    typedef struct packed {
        logic signed [15:0] goal_x;
        logic signed [15:0] goal_y;
        logic signed [15:0] goal_z;
        logic [15:0]        gain_xy;
        logic [15:0]        gain_z;
        logic [13:0]        speed_limit_xy;
        logic [13:0]        speed_limit_z;
        logic [13:0]        deadband_mm;
    } t_cfg;

    // shared multi-cycle unit request / status
    typedef struct packed {
        logic        sqrt_start;
        logic [35:0] sqrt_arg;
        logic        div_start;
        logic [29:0] div_num;
        logic [16:0] div_den;
    } t_unit_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [29:0] result;
    } t_unit_rsp;
endpackage

### hdl/position_hold_velocity_controller_unit.sv
// Top level: position-hold velocity controller.
`timescale 1ns / 1ps
// One control tick enters per input word and yields exactly one result word. A rejected fix
// or a controller that is not ready goes from the checks straight to the output; a reached
// target also takes the distance square root, navigation adds the gains, and an active
// horizontal speed limit adds the magnitude square root and two divides. The bit-serial
// square root (18 steps) and divide (30 steps) unit is shared by the distance, horizontal
// magnitude and component scaling. The block takes no new word until the previous result
// has been taken.
module position_hold_velocity_controller_unit #(
    parameter int ACCEL_LIMIT_XY    = phvc_pkg::ACCEL_LIMIT_XY_DEF,
    parameter int ACCEL_LIMIT_Z     = phvc_pkg::ACCEL_LIMIT_Z_DEF,
    parameter int SIGNAL_TIMEOUT_MS = phvc_pkg::SIGNAL_TIMEOUT_MS_DEF,
    parameter int RANGE_XY_MM       = phvc_pkg::RANGE_XY_MM_DEF,
    parameter int RANGE_Z_MM        = phvc_pkg::RANGE_Z_MM_DEF,
    parameter int MIN_Z_MM          = phvc_pkg::MIN_Z_MM_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x, pos_y, pos_z, has_pos, pos_time_ms, now_ms, fcu_ready (+6 zero bits)
    input  logic [119:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vel_x, vel_y, vel_z, nav_mode, reached_event, distance_mm (+2 zero bits)
    output logic [71:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import phvc_pkg::*;

    t_cfg      w_cfg;
    t_unit_req w_req;
    t_unit_rsp w_rsp;
    logic [69:0] w_out;

    phvc_cfg_regs u_regs (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(w_cfg)
    );

    phvc_sqdiv u_unit (.i_clk, .i_rst_n, .i_req(w_req), .o_rsp(w_rsp));

    phvc_seq #(
        .ACCEL_LIMIT_XY(ACCEL_LIMIT_XY), .ACCEL_LIMIT_Z(ACCEL_LIMIT_Z),
        .SIGNAL_TIMEOUT_MS(SIGNAL_TIMEOUT_MS), .RANGE_XY_MM(RANGE_XY_MM),
        .RANGE_Z_MM(RANGE_Z_MM), .MIN_Z_MM(MIN_Z_MM)
    ) u_seq (
        .i_clk, .i_rst_n, .i_cfg(w_cfg),
        .i_in_valid(s_axis_tvalid), .o_in_ready(s_axis_tready),
        .i_in_word(s_axis_tdata[113:0]),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .o_out_word(w_out), .o_req(w_req), .i_rsp(w_rsp)
    );

    assign m_axis_tdata = {2'b00, w_out};
endmodule

### hdl/phvc_cfg_regs.sv
// Register file: APB-style configuration port.
`timescale 1ns / 1ps
module phvc_cfg_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output phvc_pkg::t_cfg  o_cfg
);
    import phvc_pkg::*;

    t_cfg r_cfg;
    logic [2:0] w_idx;

    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.goal_x         <= 16'sd0;
            r_cfg.goal_y         <= 16'sd0;
            r_cfg.goal_z         <= 16'sd1000;
            r_cfg.gain_xy        <= 16'd205;
            r_cfg.gain_z         <= 16'd154;
            r_cfg.speed_limit_xy <= 14'd800;
            r_cfg.speed_limit_z  <= 14'd400;
            r_cfg.deadband_mm    <= 14'd100;
        end else if (psel && penable && pwrite && pready) begin
            unique case (w_idx)
                REG_TX:  r_cfg.goal_x         <= pwdata[15:0];
                REG_TY:  r_cfg.goal_y         <= pwdata[15:0];
                REG_TZ:  r_cfg.goal_z         <= pwdata[15:0];
                REG_GXY: r_cfg.gain_xy        <= pwdata[15:0];
                REG_GZ:  r_cfg.gain_z         <= pwdata[15:0];
                REG_LXY: r_cfg.speed_limit_xy <= pwdata[13:0];
                REG_LZ:  r_cfg.speed_limit_z  <= pwdata[13:0];
                REG_DB:  r_cfg.deadband_mm    <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_TX:  prdata = {{16{r_cfg.goal_x[15]}}, r_cfg.goal_x};
            REG_TY:  prdata = {{16{r_cfg.goal_y[15]}}, r_cfg.goal_y};
            REG_TZ:  prdata = {{16{r_cfg.goal_z[15]}}, r_cfg.goal_z};
            REG_GXY: prdata = {16'd0, r_cfg.gain_xy};
            REG_GZ:  prdata = {16'd0, r_cfg.gain_z};
            REG_LXY: prdata = {18'd0, r_cfg.speed_limit_xy};
            REG_LZ:  prdata = {18'd0, r_cfg.speed_limit_z};
            REG_DB:  prdata = {18'd0, r_cfg.deadband_mm};
            default: prdata = 32'd0;
        endcase
    end
endmodule

### hdl/phvc_sqdiv.sv
// Shared iterative unit: integer square root and unsigned division, one bit per cycle.
`timescale 1ns / 1ps
module phvc_sqdiv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  phvc_pkg::t_unit_req  i_req,
    output phvc_pkg::t_unit_rsp  o_rsp
);
    import phvc_pkg::*;

    logic        r_busy, r_done, r_is_div;
    logic [5:0]  r_cnt;
    logic [37:0] r_rem;
    logic [35:0] r_src;
    logic [29:0] r_res;
    logic [16:0] r_den;

    logic [37:0] w_trial;
    logic [37:0] w_shift;
    logic        w_ge;

    always_comb begin
        if (r_is_div) begin
            w_shift = {r_rem[36:0], r_src[29]};
            w_trial = w_shift - {21'd0, r_den};
        end else begin
            w_shift = {r_rem[35:0], r_src[35:34]};
            w_trial = w_shift - {6'd0, r_res, 2'b01};
        end
        w_ge = !w_trial[37];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.sqrt_start || i_req.div_start) begin
                r_busy   <= 1'b1;
                r_is_div <= i_req.div_start;
                r_rem    <= '0;
                r_res    <= '0;
                r_src    <= i_req.div_start ? {6'd0, i_req.div_num} : i_req.sqrt_arg;
                r_den    <= i_req.div_den;
                r_cnt    <= i_req.div_start ? 6'd30 : 6'd18;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_trial : w_shift;
                r_res <= {r_res[28:0], w_ge};
                r_src <= r_is_div ? {r_src[34:0], 1'b0} : {r_src[33:0], 2'b00};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("done without busy");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(i_req.sqrt_start || i_req.div_start)) else $error("start while busy");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 6'd0) else $error("count underrun");
`endif
endmodule

### hdl/phvc_seq.sv
// Sequencer: validity checks, gains, limits and rate limiting over the shared unit.
`timescale 1ns / 1ps
module phvc_seq #(
    parameter int ACCEL_LIMIT_XY    = phvc_pkg::ACCEL_LIMIT_XY_DEF,
    parameter int ACCEL_LIMIT_Z     = phvc_pkg::ACCEL_LIMIT_Z_DEF,
    parameter int SIGNAL_TIMEOUT_MS = phvc_pkg::SIGNAL_TIMEOUT_MS_DEF,
    parameter int RANGE_XY_MM       = phvc_pkg::RANGE_XY_MM_DEF,
    parameter int RANGE_Z_MM        = phvc_pkg::RANGE_Z_MM_DEF,
    parameter int MIN_Z_MM          = phvc_pkg::MIN_Z_MM_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  phvc_pkg::t_cfg       i_cfg,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [113:0]         i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [69:0]          o_out_word,
    output phvc_pkg::t_unit_req  o_req,
    input  phvc_pkg::t_unit_rsp  i_rsp
);
    import phvc_pkg::*;

    localparam logic [35:0] RXY2 = 36'(RANGE_XY_MM * RANGE_XY_MM);
    // ceil(2^34 / 1000): exact floor(x / 1000) for x below 2^24
    localparam logic [49:0] RECIP_1000 = 50'd17179870;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CHK   = 11'b00000000010,
        S_SQ    = 11'b00000000100,
        S_DIST  = 11'b00000001000,
        S_GAIN  = 11'b00000010000,
        S_HV    = 11'b00000100000,
        S_HSQ   = 11'b00001000000,
        S_DIVX  = 11'b00010000000,
        S_DIVY  = 11'b00100000000,
        S_RATE  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    logic [1:0] r_sub;
    logic signed [15:0] r_px, r_py, r_pz;
    logic r_has, r_rdy, r_valid;
    logic [31:0] r_age, r_now;
    logic signed [16:0] r_dx, r_dy, r_dz;
    logic [35:0] r_acc;
    logic [35:0] r_s2;
    logic signed [15:0] r_vx, r_vy, r_vz;
    logic [16:0] r_h;
    logic signed [15:0] r_pvx, r_pvy, r_pvz;
    logic r_was;
    logic [31:0] r_lct;
    logic [16:0] r_ldist;
    logic [2:0] r_mode;
    logic [1:0] r_evt;
    logic [31:0] r_dt;

    // shared multiplier: 17x17 signed
    logic signed [17:0] w_ma, w_mb;
    logic signed [35:0] w_prod;
    assign w_prod = w_ma * w_mb;

    logic signed [16:0] w_sel_d;
    logic [15:0] w_sel_g;
    logic signed [15:0] w_sel_v;
    logic [33:0] w_gabs, w_round;
    logic signed [17:0] w_gv;
    logic signed [15:0] w_gsat;
    logic [15:0] w_abs;
    logic [23:0] w_mxy_p, w_mz_p;
    logic [49:0] w_mxy_r, w_mz_r;
    logic [16:0] w_mxy, w_mz;
    logic [27:0] w_db2, w_lxy2;

    assign w_db2  = {14'd0, i_cfg.deadband_mm} * {14'd0, i_cfg.deadband_mm};
    assign w_lxy2 = {14'd0, i_cfg.speed_limit_xy} * {14'd0, i_cfg.speed_limit_xy};

    always_comb begin
        w_sel_d = r_sub == 2'd0 ? r_dx : (r_sub == 2'd1 ? r_dy : r_dz);
        w_sel_g = r_sub == 2'd2 ? i_cfg.gain_z : i_cfg.gain_xy;
        w_sel_v = (r_state == S_DIVY || (r_state == S_HV && r_sub == 2'd1)) ? r_vy : r_vx;
        w_ma = '0;
        w_mb = '0;
        w_gv = '0;
        unique case (r_state)
            S_CHK: begin
                w_ma = r_sub == 2'd0 ? 18'(r_px) : 18'(r_py);
                w_mb = w_ma;
            end
            S_SQ: begin
                w_ma = 18'(w_sel_d);
                w_mb = w_ma;
            end
            S_GAIN: begin
                w_ma = 18'(w_sel_d);
                w_mb = $signed({2'b00, w_sel_g});
            end
            S_HV: begin
                w_ma = 18'(w_sel_v);
                w_mb = w_ma;
            end
            default: ;
        endcase
        w_gabs  = w_prod[35] ? 34'(-w_prod) : 34'(w_prod);
        w_round = (w_gabs + 34'd128) >> 8;
        if (w_round > 34'd32767 && !w_prod[35]) w_gsat = 16'sd32767;
        else if (w_round > 34'd32768 && w_prod[35]) w_gsat = -16'sd32768;
        else begin
            w_gv   = w_prod[35] ? -$signed(18'(w_round[17:0])) : $signed(18'(w_round[17:0]));
            w_gsat = w_gv[15:0];
        end
        w_abs   = w_sel_v[15] ? 16'(-w_sel_v) : 16'(w_sel_v);
        w_mxy_p = {14'd0, r_dt[9:0]} * 24'(ACCEL_LIMIT_XY);
        w_mz_p  = {14'd0, r_dt[9:0]} * 24'(ACCEL_LIMIT_Z);
        w_mxy_r = {26'd0, w_mxy_p} * RECIP_1000;
        w_mz_r  = {26'd0, w_mz_p} * RECIP_1000;
        w_mxy   = {3'd0, w_mxy_r[47:34]};
        w_mz    = {3'd0, w_mz_r[47:34]};
    end

    function automatic logic signed [15:0] f_step(input logic signed [15:0] p,
                                                  input logic signed [15:0] w,
                                                  input logic [16:0] m);
        logic signed [17:0] d;
        logic signed [17:0] ms;
        d  = 18'(w) - 18'(p);
        ms = $signed({1'b0, m});
        if (d > ms) d = ms;
        if (d < -ms) d = -ms;
        return 16'(18'(p) + d);
    endfunction

    logic signed [15:0] w_zc;
    logic signed [15:0] w_lz;
    assign w_lz = $signed({2'b00, i_cfg.speed_limit_z});
    assign w_zc = r_vz > w_lz ? w_lz : (r_vz < -w_lz ? -w_lz : r_vz);

    logic [15:0] w_q;
    logic signed [15:0] w_qs;
    assign w_q  = i_rsp.result[15:0];
    assign w_qs = w_sel_v[15] ? -$signed(w_q) : $signed(w_q);

    always_comb begin
        o_req = '0;
        if (r_state == S_DIST && r_sub == 2'd0) begin
            o_req.sqrt_start = 1'b1;
            o_req.sqrt_arg   = r_s2;
        end
        if (r_state == S_HSQ && r_sub == 2'd0) begin
            o_req.sqrt_start = 1'b1;
            o_req.sqrt_arg   = r_acc;
        end
        if ((r_state == S_DIVX || r_state == S_DIVY) && !r_sub[1] && !r_sub[0]) begin
            o_req.div_start = 1'b1;
            o_req.div_num   = {14'd0, w_abs} * {16'd0, i_cfg.speed_limit_xy};
            o_req.div_den   = r_h;
        end
    end

    assign o_in_ready  = r_state == S_IDLE && !o_out_valid;
    assign o_out_word  = {r_ldist, r_evt, r_mode, r_pvz, r_pvy, r_pvx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sub       <= '0;
            o_out_valid <= 1'b0;
            r_pvx <= '0; r_pvy <= '0; r_pvz <= '0;
            r_was <= 1'b0; r_lct <= '0; r_ldist <= '0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_px  <= i_in_word[15:0];
                    r_py  <= i_in_word[31:16];
                    r_pz  <= i_in_word[47:32];
                    r_has <= i_in_word[48];
                    r_age <= i_in_word[112:81] - i_in_word[80:49];
                    r_now <= i_in_word[112:81];
                    r_rdy <= i_in_word[113];
                    r_sub <= '0;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_sub == 2'd0) begin
                        r_acc <= 36'(w_prod);
                        r_sub <= 2'd1;
                    end else begin
                        r_valid <= r_has && r_age <= 32'(SIGNAL_TIMEOUT_MS)
                            && (r_acc + 36'(w_prod)) <= RXY2
                            && r_pz >= 16'(MIN_Z_MM) && r_pz <= 16'(RANGE_Z_MM);
                        r_dx <= 17'(i_cfg.goal_x) - 17'(r_px);
                        r_dy <= 17'(i_cfg.goal_y) - 17'(r_py);
                        r_dz <= 17'(i_cfg.goal_z) - 17'(r_pz);
                        r_sub <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (!r_valid || !r_rdy) begin
                        r_mode <= !r_valid ? (r_has ? MODE_LOST : MODE_NO_SIGNAL)
                                           : MODE_NOT_READY;
                        r_evt <= EVT_NONE;
                        r_was <= 1'b0;
                        r_pvx <= '0; r_pvy <= '0; r_pvz <= '0;
                        r_state <= S_OUT;
                    end else begin
                        r_s2  <= (r_sub == 2'd0 ? 36'd0 : r_s2) + 36'(w_prod);
                        if (r_sub == 2'd2) begin
                            r_sub <= '0;
                            r_state <= S_DIST;
                        end else begin
                            r_sub <= r_sub + 2'd1;
                        end
                    end
                end
                S_DIST: begin
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (i_rsp.done) begin
                        r_ldist <= i_rsp.result[16:0];
                        r_sub <= '0;
                        if (r_s2 <= {8'd0, w_db2}) begin
                            r_mode <= MODE_REACHED;
                            r_evt  <= r_was ? EVT_NONE : EVT_REACHED;
                            r_was  <= 1'b1;
                            r_pvx <= '0; r_pvy <= '0; r_pvz <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_mode <= MODE_NAV;
                            r_evt  <= r_was ? EVT_LEFT : EVT_NONE;
                            r_was  <= 1'b0;
                            r_state <= S_GAIN;
                        end
                    end
                end
                S_GAIN: begin
                    unique case (r_sub)
                        2'd0: begin
                            r_vx  <= w_gsat;
                            r_sub <= 2'd1;
                        end
                        2'd1: begin
                            r_vy  <= w_gsat;
                            r_sub <= 2'd2;
                        end
                        default: begin
                            r_vz <= w_gsat;
                            r_sub <= '0;
                            r_state <= S_HV;
                        end
                    endcase
                end
                S_HV: begin
                    if (r_sub == 2'd0) begin
                        r_acc <= 36'(w_prod);
                        r_sub <= 2'd1;
                    end else begin
                        r_acc <= r_acc + 36'(w_prod);
                        r_vz  <= w_zc;
                        r_dt  <= r_now - r_lct;
                        r_lct <= r_now;
                        r_sub <= '0;
                        r_state <= (r_acc + 36'(w_prod)) > {8'd0, w_lxy2}
                            ? S_HSQ : S_RATE;
                    end
                end
                S_HSQ: begin
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (i_rsp.done) begin
                        r_h <= i_rsp.result[16:0];
                        r_sub <= '0;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX, S_DIVY: begin
                    if (r_sub == 2'd0) r_sub <= 2'd1;
                    else if (i_rsp.done) begin
                        r_sub <= '0;
                        if (r_state == S_DIVX) begin
                            r_vx <= w_qs;
                            r_state <= S_DIVY;
                        end else begin
                            r_vy <= w_qs;
                            r_state <= S_RATE;
                        end
                    end
                end
                S_RATE: begin
                    if (r_dt != 32'd0 && r_dt < 32'd1000) begin
                        r_pvx <= f_step(r_pvx, r_vx, w_mxy);
                        r_pvy <= f_step(r_pvy, r_vy, w_mxy);
                        r_pvz <= f_step(r_pvz, r_vz, w_mz);
                    end else begin
                        r_pvx <= r_vx; r_pvy <= r_vy; r_pvz <= r_vz;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT)) else $error("result out of order");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_reached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && r_mode != MODE_NAV |-> r_pvx == 16'sd0 && r_pvz == 16'sd0)
        else $error("velocity not zero");
`endif
endmodule

### bench/position_hold_velocity_controller_unit_tb.sv
// Testbench: random and directed control ticks checked against a fixed-point controller model.
`timescale 1ns / 1ps
module position_hold_velocity_controller_unit_tb;
    import phvc_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 300;

    typedef struct {
        logic signed [15:0] px, py, pz;
        logic               has;
        logic [31:0]        pt, now;
        logic               rdy;
    } tick_t;

    typedef struct {
        logic [15:0] vx, vy, vz;
        logic [2:0]  mode;
        logic [1:0]  evt;
        logic [16:0] dist_mm;
    } cmd_t;

    logic         i_clk, i_rst_n;
    logic         s_axis_tvalid, s_axis_tready;
    logic [119:0] s_axis_tdata;
    logic         m_axis_tvalid, m_axis_tready;
    logic [71:0]  m_axis_tdata;
    logic         psel, penable, pwrite, pready;
    logic [4:0]   paddr;
    logic [31:0]  pwdata, prdata;

    position_hold_velocity_controller_unit DUT (.*);

    // controller model state and registers
    int          tgt_x, tgt_y, tgt_z;
    int unsigned g_xy, g_z, lim_xy, lim_z, dband;
    int          pv_x, pv_y, pv_z;
    bit          reached_q;
    logic [31:0] last_cmd_ms;
    logic [16:0] last_dist;

    tick_t tick_q[$];
    cmd_t  cmd_q[$];
    tick_t cur_tick;
    int    send_idle_pct, recv_idle_pct;
    int    errors, idle_cycles;
    int    clock_ms;

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic int sat16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int prop_vel(int unsigned g, int d);
        longint p, r;
        p = longint'(g) * d;
        r = ((p < 0 ? -p : p) + 128) >>> 8;
        return sat16(p < 0 ? -r : r);
    endfunction

    function automatic int slew(int prv, int want, longint maxd);
        longint dl;
        dl = longint'(want) - prv;
        if (dl > maxd) dl = maxd;
        if (dl < -maxd) dl = -maxd;
        return int'(prv + dl);
    endfunction

    function automatic cmd_t control_step(tick_t t);
        cmd_t c;
        int vx, vy, vz, dx, dy, dz;
        bit valid;
        longint unsigned s2, hv2, h, ax, ay, lim;
        longint sx, sy;
        logic [31:0] age, dt;
        vx = 0; vy = 0; vz = 0;
        c.evt = EVT_NONE;
        valid = 0;
        age = t.now - t.pt;
        if (t.has && age <= SIGNAL_TIMEOUT_MS_DEF &&
            longint'(t.px) * t.px + longint'(t.py) * t.py <=
                longint'(RANGE_XY_MM_DEF) * RANGE_XY_MM_DEF &&
            int'(t.pz) >= MIN_Z_MM_DEF && int'(t.pz) <= RANGE_Z_MM_DEF)
            valid = 1;
        if (!valid) begin
            c.mode = t.has ? MODE_LOST : MODE_NO_SIGNAL;
            reached_q = 0;
        end else if (!t.rdy) begin
            c.mode = MODE_NOT_READY;
            reached_q = 0;
        end else begin
            dx = tgt_x - t.px; dy = tgt_y - t.py; dz = tgt_z - t.pz;
            s2 = longint'(dx) * dx + longint'(dy) * dy + longint'(dz) * dz;
            last_dist = isqrt(s2);
            if (s2 <= longint'(dband) * dband) begin
                c.mode = MODE_REACHED;
                if (!reached_q) c.evt = EVT_REACHED;
                reached_q = 1;
            end else begin
                c.mode = MODE_NAV;
                if (reached_q) c.evt = EVT_LEFT;
                reached_q = 0;
                vx = prop_vel(g_xy, dx);
                vy = prop_vel(g_xy, dy);
                vz = prop_vel(g_z, dz);
                lim = lim_xy;
                hv2 = longint'(vx) * vx + longint'(vy) * vy;
                if (hv2 > lim * lim) begin
                    h = isqrt(hv2);
                    ax = vx < 0 ? -vx : vx;
                    ay = vy < 0 ? -vy : vy;
                    sx = ax * lim / h;
                    sy = ay * lim / h;
                    vx = vx < 0 ? -sx : sx;
                    vy = vy < 0 ? -sy : sy;
                end
                if (vz > int'(lim_z)) vz = lim_z;
                if (vz < -int'(lim_z)) vz = -int'(lim_z);
                dt = t.now - last_cmd_ms;
                last_cmd_ms = t.now;
                if (dt > 0 && dt < 1000) begin
                    vx = slew(pv_x, vx, longint'(ACCEL_LIMIT_XY_DEF) * dt / 1000);
                    vy = slew(pv_y, vy, longint'(ACCEL_LIMIT_XY_DEF) * dt / 1000);
                    vz = slew(pv_z, vz, longint'(ACCEL_LIMIT_Z_DEF) * dt / 1000);
                end
            end
        end
        pv_x = vx; pv_y = vy; pv_z = vz;
        c.vx = vx; c.vy = vy; c.vz = vz;
        c.dist_mm = last_dist;
        return c;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) cmd_q.push_back(control_step(cur_tick));
            if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_tick = tick_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'b0, cur_tick.rdy, cur_tick.now, cur_tick.pt, cur_tick.has,
                                 cur_tick.pz, cur_tick.py, cur_tick.px};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cmd_t want, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (m_axis_tvalid && m_axis_tready) begin
                got.vx = m_axis_tdata[15:0];
                got.vy = m_axis_tdata[31:16];
                got.vz = m_axis_tdata[47:32];
                got.mode = m_axis_tdata[50:48];
                got.evt = m_axis_tdata[52:51];
                got.dist_mm = m_axis_tdata[69:53];
                if (cmd_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected word %h", m_axis_tdata);
                end else begin
                    want = cmd_q.pop_front();
                    if (got.vx !== want.vx || got.vy !== want.vy || got.vz !== want.vz ||
                        got.mode !== want.mode || got.evt !== want.evt ||
                        got.dist_mm !== want.dist_mm) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch exp v=%0d/%0d/%0d m=%0d e=%0d d=%0d",
                                $signed(want.vx), $signed(want.vy), $signed(want.vz),
                                want.mode, want.evt, want.dist_mm,
                                " got v=%0d/%0d/%0d m=%0d e=%0d d=%0d",
                                $signed(got.vx), $signed(got.vy), $signed(got.vz),
                                got.mode, got.evt, got.dist_mm);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, int val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_TX:  tgt_x = $signed(val[15:0]);
            REG_TY:  tgt_y = $signed(val[15:0]);
            REG_TZ:  tgt_z = $signed(val[15:0]);
            REG_GXY: g_xy = val[15:0];
            REG_GZ:  g_z = val[15:0];
            REG_LXY: lim_xy = val[13:0];
            REG_LZ:  lim_z = val[13:0];
            REG_DB:  dband = val[13:0];
            default: ;
        endcase
    endtask

    task automatic write_all(int tx, int ty, int tz, int gxy, int gz, int lxy, int lz, int db);
        reg_write(REG_TX, tx);  reg_write(REG_TY, ty);  reg_write(REG_TZ, tz);
        reg_write(REG_GXY, gxy); reg_write(REG_GZ, gz);
        reg_write(REG_LXY, lxy); reg_write(REG_LZ, lz); reg_write(REG_DB, db);
    endtask

    task automatic add_tick(int px, int py, int pz, bit has, int unsigned pt,
                            int unsigned now, bit rdy);
        tick_t t;
        t.px = px; t.py = py; t.pz = pz; t.has = has;
        t.pt = pt; t.now = now; t.rdy = rdy;
        tick_q.push_back(t);
    endtask

    task automatic add_random_tick();
        int sel, off, span;
        sel = $urandom_range(99);
        if (sel < 15) begin
            add_tick($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            clock_ms += (sel < 18) ? 0 : (sel < 21) ? $urandom_range(1000, 5000)
                                               : $urandom_range(1, 150);
            case ($urandom_range(3))
                0: span = dband + 20;
                1: span = 300;
                2: span = 3000;
                default: span = 15000;
            endcase
            off = $urandom_range(2 * span) - span;
            add_tick(tgt_x + off, tgt_y + $urandom_range(2 * span) - span,
                     ($urandom_range(1)) ? $urandom_range(250, 5050)
                                         : tgt_z + $urandom_range(2 * span) - span,
                     $urandom_range(49) != 0,
                     clock_ms - (($urandom_range(19) == 0) ? $urandom_range(501, 2000)
                                                         : $urandom_range(0, 500)),
                     clock_ms, $urandom_range(19) != 0);
        end
    endtask

    task automatic drain();
        while (tick_q.size() > 0 || s_axis_tvalid || cmd_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 0; s_axis_tvalid = 0; s_axis_tdata = '0; m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        errors = 0; idle_cycles = 0; send_idle_pct = 0; recv_idle_pct = 0;
        tgt_x = 0; tgt_y = 0; tgt_z = 1000; g_xy = 205; g_z = 154;
        lim_xy = 800; lim_z = 400; dband = 100;
        pv_x = 0; pv_y = 0; pv_z = 0; reached_q = 0; last_cmd_ms = 0; last_dist = 0;
        clock_ms = 1000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: rejections, boundaries, reach/leave, timing corners
        add_tick(0, 0, 1000, 0, 0, 0, 1);
        add_tick(-32768, 32767, -32768, 1, 100, 100, 1);
        add_tick(15000, 0, 300, 1, 100, 100, 1);
        add_tick(15000, 1, 300, 1, 100, 100, 1);
        add_tick(0, 0, 299, 1, 100, 100, 1);
        add_tick(0, 0, 5000, 1, 100, 600, 1);
        add_tick(0, 0, 5001, 1, 100, 600, 1);
        add_tick(0, 0, 1000, 1, 100, 601, 1);
        add_tick(0, 0, 1000, 1, 700, 600, 1);
        add_tick(0, 0, 1000, 1, 700, 700, 0);
        add_tick(0, 0, 1000, 1, 800, 800, 1);
        add_tick(50, 50, 1000, 1, 850, 850, 1);
        add_tick(5000, -5000, 3000, 1, 900, 900, 1);
        add_tick(5000, -5000, 3000, 1, 950, 950, 1);
        add_tick(5000, -5000, 3000, 1, 950, 950, 1);
        add_tick(-10000, 10000, 300, 1, 2500, 2500, 1);
        add_tick(0, 0, 1000, 1, 2600, 2600, 1);
        add_tick(3000, 0, 1000, 1, 2700, 2700, 1);
        add_tick(3000, 0, 1000, 1, 32'hFFFF_FF00, 32'hFFFF_FFF0, 1);
        add_tick(3000, 0, 1000, 1, 32'hFFFF_FFF0, 32'h0000_0050, 1);
        add_tick(3000, 0, 1000, 1, 32'h0000_0060, 32'h0000_0050, 1);
        add_tick(-3000, 2000, 4000, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
        clock_ms = 32'h0000_1000;
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 78; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 78; end
                default: begin send_idle_pct = 31; recv_idle_pct = 31; end
            endcase
            case (ph)
                0: ;
                1: write_all(32767, -32768, 32767, 65535, 65535, 10000, 10000, 10000);
                2: write_all(-32768, 32767, -32768, 3, 3, 100, 100, 0);
                3: write_all(0, 0, 1000, 205, 154, 800, 400, 100);
                default: write_all($urandom_range(0, 8000) - 4000,
                                   $urandom_range(0, 8000) - 4000,
                                   $urandom_range(300, 5000), $urandom_range(3, 65535),
                                   $urandom_range(3, 65535), $urandom_range(100, 10000),
                                   $urandom_range(100, 10000), $urandom_range(0, 10000));
            endcase
            for (int n = 0; n < 185; n++) add_random_tick();
            drain();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

### filelist.f
hdl/phvc_pkg.sv
hdl/phvc_cfg_regs.sv
hdl/phvc_sqdiv.sv
hdl/phvc_seq.sv
hdl/position_hold_velocity_controller_unit.sv
bench/position_hold_velocity_controller_unit_tb.sv
